### hw/rtl/ssnf_pkg.sv
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared types and constants of the seven-segment number formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssnf_pkg;

    localparam int NUM_W   = 32;   // input value
    localparam int DEC_W   = 27;   // enough for 99999999
    localparam int HALF_W  = 14;   // four decimal digits
    localparam int PAIR_W  = 7;    // two decimal digits
    localparam int NIB_W   = 4;
    localparam int CODE_W  = 5;
    localparam int PTS_W   = 4;
    localparam int WORD_W  = 28;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 64;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 5;

    localparam logic [NUM_W-1:0] DEC_LIMIT = 32'd99999999;

    // floor(v / 10000) via reciprocal, low by at most one
    localparam logic [HALF_W-1:0] RCP_10K     = 14'd13421;
    localparam int                RCP_10K_SH  = 27;
    localparam logic [HALF_W-1:0] TEN_K       = 14'd10000;
    // floor(x / 100), exact below 10000
    localparam logic [12:0]       RCP_100     = 13'd5243;
    localparam int                RCP_100_SH  = 19;
    localparam logic [PAIR_W-1:0] HUNDRED     = 7'd100;
    // floor(y / 10), exact below 100
    localparam logic [PAIR_W-1:0] RCP_10      = 7'd103;
    localparam int                RCP_10_SH   = 10;
    localparam logic [NIB_W-1:0]  TEN         = 4'd10;

    // config register indexes
    localparam logic [CIDX_W-1:0] CFG_BLANK_CODE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LOW_POINTS  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HIGH_POINTS = 2'd2;

    localparam logic [CODE_W-1:0] BLANK_RESET = 5'd31;

    typedef enum logic {
        OP_DEC = 1'b0,
        OP_HEX = 1'b1
    } t_op;

    // per-request control carried beside the datapath
    typedef struct packed {
        t_op              op;
        logic             trim;
        logic             err;
        logic [NUM_W-1:0] num;
    } t_side;

    typedef logic [CODE_W-1:0] t_code;

    function automatic logic [WORD_W-1:0] pack_bank(
        input t_code            d3,
        input t_code            d2,
        input t_code            d1,
        input t_code            d0,
        input logic [PTS_W-1:0] pts
    );
        pack_bank = {pts, 1'b0, d3, 1'b0, d2, 1'b0, d1, 1'b0, d0};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ssnf_div10k.sv
// ----------------------------------------------------------------------------
// ssnf_div10k
// Two-stage split of a value below 10^8 into upper and lower four digits.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnf_div10k
    import ssnf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DEC_W-1:0]  i_value,
    output logic      [HALF_W-1:0] o_upper,
    output logic      [HALF_W-1:0] o_lower
);

    logic [DEC_W+HALF_W-1:0] w_prod;
    logic [HALF_W-1:0]       n_q0;
    logic [HALF_W-1:0]       r_q0;
    logic [DEC_W-1:0]        r_value;
    logic [DEC_W-1:0]        w_back;
    logic [DEC_W-1:0]        w_diff;
    logic [HALF_W:0]         w_rem;
    logic [HALF_W-1:0]       n_upper;
    logic [HALF_W-1:0]       n_lower;

    // stage a: estimated quotient
    assign w_prod = DEC_W'(i_value) * RCP_10K;
    assign n_q0   = w_prod[DEC_W+HALF_W-1:RCP_10K_SH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0    <= n_q0;
            r_value <= i_value;
        end
    end

    // stage b: remainder and one-step correction
    assign w_back = DEC_W'(r_q0) * DEC_W'(TEN_K);
    assign w_diff = r_value - w_back;
    assign w_rem  = w_diff[HALF_W:0];

    always_comb begin
        if (w_rem >= {1'b0, TEN_K}) begin
            n_upper = r_q0 + 1'b1;
            n_lower = HALF_W'(w_rem - {1'b0, TEN_K});
        end else begin
            n_upper = r_q0;
            n_lower = w_rem[HALF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_upper <= n_upper;
            o_lower <= n_lower;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ssnf_div100.sv
// ----------------------------------------------------------------------------
// ssnf_div100
// Two-stage split of a four-digit value into two two-digit values.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnf_div100
    import ssnf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [HALF_W-1:0] i_value,
    output logic      [PAIR_W-1:0] o_upper,
    output logic      [PAIR_W-1:0] o_lower
);

    logic [HALF_W+12:0] w_prod;
    logic [PAIR_W-1:0]  n_q;
    logic [PAIR_W-1:0]  r_q;
    logic [HALF_W-1:0]  r_value;
    logic [HALF_W-1:0]  w_back;
    logic [HALF_W-1:0]  w_diff;

    // stage a: quotient by reciprocal
    assign w_prod = (HALF_W+13)'(i_value) * RCP_100;
    assign n_q    = w_prod[RCP_100_SH+PAIR_W-1:RCP_100_SH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q     <= n_q;
            r_value <= i_value;
        end
    end

    // stage b: remainder
    assign w_back = HALF_W'(r_q) * HALF_W'(HUNDRED);
    assign w_diff = r_value - w_back;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_upper <= r_q;
            o_lower <= w_diff[PAIR_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ssnf_pack.sv
// ----------------------------------------------------------------------------
// ssnf_pack
// Final digit split, leading-zero blanking and bank word packing.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnf_pack
    import ssnf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_side             i_side,
    input  wire logic [PAIR_W-1:0] i_pair_hh,
    input  wire logic [PAIR_W-1:0] i_pair_hl,
    input  wire logic [PAIR_W-1:0] i_pair_lh,
    input  wire logic [PAIR_W-1:0] i_pair_ll,
    input  wire t_code             i_blank_code,
    input  wire logic [PTS_W-1:0]  i_low_points,
    input  wire logic [PTS_W-1:0]  i_high_points,
    output logic      [WORD_W-1:0] o_high_word,
    output logic      [WORD_W-1:0] o_low_word,
    output logic                   o_range_error
);

    logic [PAIR_W-1:0]   w_pair [4];
    t_code               w_dig  [8];
    logic [WORD_W-1:0]   n_high;
    logic [WORD_W-1:0]   n_low;

    assign w_pair[3] = i_pair_hh;
    assign w_pair[2] = i_pair_hl;
    assign w_pair[1] = i_pair_lh;
    assign w_pair[0] = i_pair_ll;

    always_comb begin
        logic [2*PAIR_W-1:0] prod;
        logic [NIB_W-1:0]    tens;
        logic [PAIR_W-1:0]   ones;
        logic                lead;
        for (int p = 0; p < 4; p++) begin
            prod = (2*PAIR_W)'(w_pair[p]) * (2*PAIR_W)'(RCP_10);
            tens = prod[RCP_10_SH+NIB_W-1:RCP_10_SH];
            ones = w_pair[p] - (PAIR_W'(tens) * PAIR_W'(TEN));
            if (i_side.op == OP_HEX) begin
                w_dig[2*p+1] = CODE_W'(i_side.num[(2*p+1)*NIB_W +: NIB_W]);
                w_dig[2*p]   = CODE_W'(i_side.num[(2*p)*NIB_W +: NIB_W]);
            end else begin
                w_dig[2*p+1] = CODE_W'(tens);
                w_dig[2*p]   = CODE_W'(ones[NIB_W-1:0]);
            end
        end
        // blank leading zeros from the top, units digit always shown
        lead = (i_side.op == OP_DEC) && i_side.trim;
        for (int k = 7; k >= 1; k--) begin
            if (lead && (w_dig[k] == '0)) begin
                w_dig[k] = i_blank_code;
            end else begin
                lead = 1'b0;
            end
        end
    end

    always_comb begin
        if (i_side.err) begin
            n_high = '0;
            n_low  = '0;
        end else begin
            n_high = pack_bank(w_dig[7], w_dig[6], w_dig[5], w_dig[4], i_high_points);
            n_low  = pack_bank(w_dig[3], w_dig[2], w_dig[1], w_dig[0], i_low_points);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_high_word   <= n_high;
            o_low_word    <= n_low;
            o_range_error <= i_side.err;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/seven_segment_number_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// Formats a 32-bit value as eight display digit codes in two bank words.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output side is not stalled and
// returns one result per request, in order. A request passes through the
// input register, then two stages of the divide-by-10000 reciprocal
// multiply, two stages of the divide-by-100 multiply, and the digit/pack
// stage into the output register, which drives o_m_tvalid. The pipeline
// advances as a whole whenever the output register is empty or being taken,
// so o_s_tready depends combinationally on i_m_tready. Decimal values above
// 99999999 give range_error with both words zero. Write the config registers
// only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_number_formatter
    import ssnf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config write port
    input  wire logic               i_cfg_we,
    input  wire logic [CIDX_W-1:0]  i_cfg_index,
    input  wire logic [CDATA_W-1:0] i_cfg_data,
    // request side
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [IN_W-1:0]    i_s_tdata,   // opcode[0], number[32:1], trim_zeros[33]
    // result side
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic      [OUT_W-1:0]   o_m_tdata    // high_word[27:0], low_word[55:28],
                                                 // range_error[56]
);

    t_code             r_blank_code;
    logic [PTS_W-1:0]  r_low_points;
    logic [PTS_W-1:0]  r_high_points;

    logic              w_en;
    t_side             n_sd1;
    t_side             r_sd1, r_sd2, r_sd3, r_sd4, r_sd5;
    logic              r_v1, r_v2, r_v3, r_v4, r_v5, r_out_vld;

    logic [HALF_W-1:0] w_upper4, w_lower4;
    logic [PAIR_W-1:0] w_hh, w_hl, w_lh, w_ll;
    logic [WORD_W-1:0] w_high_word, w_low_word;
    logic              w_range_error;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_code  <= BLANK_RESET;
            r_low_points  <= '0;
            r_high_points <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLANK_CODE:  r_blank_code  <= i_cfg_data;
                CFG_LOW_POINTS:  r_low_points  <= i_cfg_data[PTS_W-1:0];
                CFG_HIGH_POINTS: r_high_points <= i_cfg_data[PTS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    always_comb begin
        n_sd1.op   = t_op'(i_s_tdata[0]);
        n_sd1.num  = i_s_tdata[NUM_W:1];
        n_sd1.trim = i_s_tdata[NUM_W+1];
        n_sd1.err  = (n_sd1.op == OP_DEC) && (n_sd1.num > DEC_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_v1      <= i_s_tvalid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_out_vld <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd1 <= n_sd1;
            r_sd2 <= r_sd1;
            r_sd3 <= r_sd2;
            r_sd4 <= r_sd3;
            r_sd5 <= r_sd4;
        end
    end

    ssnf_div10k u_div10k (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (r_sd1.num[DEC_W-1:0]),
        .o_upper (w_upper4),
        .o_lower (w_lower4)
    );

    ssnf_div100 u_div100_hi (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (w_upper4),
        .o_upper (w_hh),
        .o_lower (w_hl)
    );

    ssnf_div100 u_div100_lo (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (w_lower4),
        .o_upper (w_lh),
        .o_lower (w_ll)
    );

    ssnf_pack u_pack (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_side        (r_sd5),
        .i_pair_hh     (w_hh),
        .i_pair_hl     (w_hl),
        .i_pair_lh     (w_lh),
        .i_pair_ll     (w_ll),
        .i_blank_code  (r_blank_code),
        .i_low_points  (r_low_points),
        .i_high_points (r_high_points),
        .o_high_word   (w_high_word),
        .o_low_word    (w_low_word),
        .o_range_error (w_range_error)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'b0, w_range_error, w_low_word, w_high_word};

    // an out-of-range result carries no digits or points
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2*WORD_W] |-> o_m_tdata[2*WORD_W-1:0] == '0)
        else $error("range error with nonzero words");

    // the whole pipeline steps together
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_v4 |=> r_v5)
        else $error("pipeline valid lost between stages");

    // hold when the output is stalled
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v1) && $stable(r_v5) && $stable(r_sd5))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire
